/* hdl/rle_row_map_decoder_defines.svh */
// assertion macros for the run-length tile map decoder
// no dependencies; included by the modules that carry assertions
`ifndef RLE_ROW_MAP_DECODER_DEFINES_SVH
`define RLE_ROW_MAP_DECODER_DEFINES_SVH

// clocked property, disabled while reset is low
`define RRMD_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property, checked during reset as well
`define RRMD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rrmd_pkg.sv */
// shared types and constants of the run-length tile map decoder
// no dependencies
package rrmd_pkg;

    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_ROW_SHIFT    = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_BASE_ADDRESS = 2'd3;

    localparam logic [7:0]  RowWidthReset    = 8'd30;
    localparam logic [7:0]  RowCountReset    = 8'd20;
    localparam logic [3:0]  RowShiftReset    = 4'd5;
    localparam logic [15:0] BaseAddressReset = 16'd0;

    localparam logic [7:0]  MinRowWidth = 8'd8;
    localparam logic [7:0]  MinRowCount = 8'd1;

    typedef struct packed {
        logic        frame_start;
        logic [7:0]  run_count;
        logic [15:0] run_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] seg_address;
        logic [7:0]  seg_length;
        logic [15:0] seg_value;
        logic        run_last;
        logic        frame_done;
        logic        overflow;
    } out_item_t;

    // effective map geometry seen by the datapath
    typedef struct packed {
        logic [7:0]  width;
        logic [7:0]  rows;
        logic [3:0]  shift;
        logic [15:0] base;
    } map_cfg_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic seg_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/rrmd_cfg_regs.sv */
// configuration registers of the tile map decoder, with clamped geometry
// depends on rrmd_pkg
module rrmd_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rrmd_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [15:0]                         cfg_data,
    output rrmd_pkg::map_cfg_t                  map_cfg
);
    import rrmd_pkg::*;

    logic [7:0]  row_width_reg;
    logic [7:0]  row_count_reg;
    logic [3:0]  row_shift_reg;
    logic [15:0] base_address_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= RowWidthReset;
            row_count_reg    <= RowCountReset;
            row_shift_reg    <= RowShiftReset;
            base_address_reg <= BaseAddressReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROW_WIDTH:    row_width_reg    <= cfg_data[7:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[7:0];
                REG_ROW_SHIFT:    row_shift_reg    <= cfg_data[3:0];
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        map_cfg.width = (row_width_reg < MinRowWidth) ? MinRowWidth : row_width_reg;
        map_cfg.rows  = (row_count_reg < MinRowCount) ? MinRowCount : row_count_reg;
        map_cfg.shift = row_shift_reg;
        map_cfg.base  = base_address_reg;
    end

endmodule

/* hdl/rrmd_datapath.sv */
// position state, run working registers, segment cutter and result register
// depends on rrmd_pkg
module rrmd_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rrmd_pkg::map_cfg_t      map_cfg,
    input  rrmd_pkg::ctrl_cmd_t     cmd,
    input  rrmd_pkg::in_item_t      s_item,
    output rrmd_pkg::dp_status_t    status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rrmd_pkg::out_item_t     m_item
);
    import rrmd_pkg::*;

    logic [7:0]  col_reg,  col_next;
    logic [7:0]  row_reg,  row_next;
    logic        comp_reg, comp_next;
    logic [7:0]  rem_reg;
    logic [15:0] val_reg;
    logic        skip_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    // load-time normalization
    logic [7:0] c0, r0, c1;
    logic       comp0;
    logic [8:0] r1;
    logic       comp1;

    // segment step
    logic [7:0]  room, seg, col_sum, rem_left;
    logic        wrap, fin, last;
    logic [8:0]  row_inc;
    logic [15:0] row_off, addr;
    out_item_t   seg_item;

    always_comb begin
        c0    = s_item.frame_start ? 8'd0 : col_reg;
        r0    = s_item.frame_start ? 8'd0 : row_reg;
        comp0 = s_item.frame_start ? 1'b0 : comp_reg;
        if (c0 >= map_cfg.width) begin
            c1 = 8'd0;
            r1 = {1'b0, r0} + 9'd1;
        end else begin
            c1 = c0;
            r1 = {1'b0, r0};
        end
        comp1 = comp0 || (r1 >= {1'b0, map_cfg.rows});
    end

    always_comb begin
        room     = map_cfg.width - col_reg;
        seg      = skip_reg ? 8'd0 : ((rem_reg < room) ? rem_reg : room);
        col_sum  = col_reg + seg;
        wrap     = !skip_reg && (col_sum >= map_cfg.width);
        row_inc  = {1'b0, row_reg} + 9'd1;
        fin      = wrap && (row_inc >= {1'b0, map_cfg.rows});
        rem_left = rem_reg - seg;
        last     = skip_reg || fin || (rem_left == 8'd0);
        row_off  = 16'({8'd0, row_reg} << map_cfg.shift);
        addr     = map_cfg.base + row_off + {8'd0, col_reg};
        if (skip_reg) begin
            seg_item = '{seg_address: 16'd0, seg_length: 8'd0, seg_value: 16'd0,
                         run_last: 1'b1, frame_done: 1'b0, overflow: 1'b1};
        end else begin
            seg_item = '{seg_address: addr, seg_length: seg, seg_value: val_reg,
                         run_last: last, frame_done: fin, overflow: 1'b0};
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        comp_next = comp_reg;
        if (cmd.load) begin
            if (!comp0) begin
                col_next = c1;
                row_next = r1[7:0];
            end
            comp_next = comp1;
        end else if (cmd.step && !skip_reg) begin
            col_next  = wrap ? 8'd0 : col_sum;
            row_next  = wrap ? row_inc[7:0] : row_reg;
            comp_next = comp_reg || fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            comp_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            comp_reg <= comp_next;
            if (cmd.load) begin
                skip_reg <= comp1;
            end
            if (cmd.step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg <= s_item.run_count;
            val_reg <= s_item.run_value;
        end else if (cmd.step) begin
            rem_reg <= rem_left;
        end
        if (cmd.step) begin
            out_reg <= seg_item;
        end
    end

    assign status.seg_last = last;
    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_item          = out_reg;

endmodule

/* hdl/rrmd_ctrl.sv */
// controller of the tile map decoder: takes a run, then issues segment steps
// depends on rrmd_pkg and rle_row_map_decoder_defines.svh
`include "rle_row_map_decoder_defines.svh"

module rrmd_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  rrmd_pkg::dp_status_t    status,
    output rrmd_pkg::ctrl_cmd_t     cmd
);
    import rrmd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg, state_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = s_valid && s_ready;
    assign cmd.step = (state_reg == ST_BUSY) && status.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (cmd.step && status.seg_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RRMD_ASSERT(a_load_enters_busy, aclk, aresetn, cmd.load |=> (state_reg == ST_BUSY), "load did not start segment steps")
    `RRMD_ASSERT(a_last_returns_idle, aclk, aresetn, (cmd.step && status.seg_last) |=> (state_reg == ST_IDLE), "last segment did not end the run")
    `RRMD_ASSERT_ALWAYS(a_step_needs_room, aclk, cmd.step |-> status.out_free, "segment step while result register full")

endmodule

/* hdl/rle_row_map_decoder.sv */
// top level of the run-length tile map decoder
// depends on rrmd_pkg, rrmd_cfg_regs, rrmd_datapath, rrmd_ctrl
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_item  (rrmd_pkg::in_item_t)
//  m_        out        m_valid / m_ready    m_item  (rrmd_pkg::out_item_t)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a run is accepted, then its segments are stepped out; zero-count and overflow runs give one segment
// the segment cutter produces one segment per cycle, unless stalled, into a single result register
// a full result register that is not taken stalls the segment steps, and with them
// the next run; a last segment left waiting does not hold off the next run's accept
// reset (synchronous, active low) restores default geometry and position 0,0
module rle_row_map_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // run input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rrmd_pkg::in_item_t                  s_item,
    // segment output
    output logic                                m_valid,
    input  logic                                m_ready,
    output rrmd_pkg::out_item_t                 m_item,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rrmd_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [15:0]                         cfg_data
);
    import rrmd_pkg::*;

    // clamped map geometry
    map_cfg_t   map_cfg;
    // controller to datapath
    ctrl_cmd_t  cmd;
    // datapath to controller: last segment of run, result register can take one
    dp_status_t status;

    rrmd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map_cfg   (map_cfg)
    );

    // sequencing: idle takes a run, busy emits its segments
    rrmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // position tracking, segment cut at row ends, address generation
    rrmd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .map_cfg (map_cfg),
        .cmd     (cmd),
        .s_item  (s_item),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
